>>> hw/rtl/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and codes for the indexed list engine: command and status
// codes, and the payload layouts of the command and result channels.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int unsigned POS_BITS   = 5;
    localparam int unsigned VALUE_BITS = 32;
    localparam int unsigned FP_BITS    = 4;
    localparam int unsigned COUNT_BITS = 5;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_FIND   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                  command;
        logic [POS_BITS-1:0]   position;
        logic [VALUE_BITS-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        status_t               status;
        logic [VALUE_BITS-1:0] read_value;
        logic [FP_BITS-1:0]    found_position;
        logic [COUNT_BITS-1:0] entry_count;
    } rsp_item_t;

endpackage

>>> hw/rtl/ile_chan_if.sv
// ----------------------------------------------------------------------------
// ile_chan_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface ile_chan_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

>>> hw/rtl/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded ordered list of words with read, insert, erase and find commands.
// ----------------------------------------------------------------------------
// One command is worked at a time; each gives exactly one result item. The
// list lives in a single memory with one write and one registered read port,
// and every shift or search moves one entry per cycle through that port pair.
// A read waits for the registered read port. An insert moves the entries
// at and above its position up one place, top first, then writes the word;
// an erase moves those above its position down, lowest first; a find scans
// from entry 0 to the first hit or the list's end. A new command is taken as
// soon as the previous one has left its result in the output register, even
// if that result has not been taken yet.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
    parameter int unsigned CAPACITY  = 16,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    ile_chan_if.sink   cmd,
    ile_chan_if.source rsp
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned PW = (CW > ile_pkg::POS_BITS) ? CW : ile_pkg::POS_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_SHIFT,
        S_PUT,
        S_RESULT
    } state_t;

    state_t                        state_reg, state_next;
    ile_pkg::cmd_t                 op_reg, op_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic [WORD_BITS-1:0]          val_reg, val_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 rem_reg, rem_next;
    logic [AW-1:0]                 src_reg, src_next;
    logic [AW-1:0]                 dst_reg, dst_next;
    logic                          pv_reg, pv_next;
    ile_pkg::status_t              res_status_reg, res_status_next;
    logic [ile_pkg::VALUE_BITS-1:0] res_rd_reg, res_rd_next;
    logic [ile_pkg::FP_BITS-1:0]   res_fp_reg, res_fp_next;
    ile_pkg::rsp_item_t            out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;

    // list memory
    logic [WORD_BITS-1:0] mem [CAPACITY];
    logic [WORD_BITS-1:0] mem_rd_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;

    logic [PW-1:0] cmd_pos_ext;
    logic [PW-1:0] count_ext;

    assign cmd.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    assign cmd_pos_ext = PW'(cmd.payload.position);
    assign count_ext   = PW'(count_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        pv_next         = pv_reg;
        res_status_next = res_status_reg;
        res_rd_next     = res_rd_reg;
        res_fp_next     = res_fp_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        mem_we          = 1'b0;
        mem_waddr       = dst_reg;
        mem_wdata       = mem_rd_reg;
        mem_re          = 1'b0;
        mem_raddr       = src_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next         = cmd.payload.command;
                    pos_next        = AW'(cmd.payload.position);
                    val_next        = WORD_BITS'(cmd.payload.value);
                    res_status_next = ile_pkg::ST_OK;
                    res_rd_next     = '0;
                    res_fp_next     = '0;
                    pv_next         = 1'b0;
                    unique case (cmd.payload.command)
                        ile_pkg::CMD_READ:
                        begin
                            if (cmd_pos_ext >= count_ext)
                            begin
                                res_status_next = ile_pkg::ST_BAD_POS;
                                state_next      = S_RESULT;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(cmd.payload.position);
                                state_next = S_RDWAIT;
                            end
                        end
                        ile_pkg::CMD_INSERT:
                        begin
                            if (cmd_pos_ext > count_ext)
                            begin
                                res_status_next = ile_pkg::ST_BAD_POS;
                                state_next      = S_RESULT;
                            end
                            else if (count_reg == CW'(CAPACITY))
                            begin
                                res_status_next = ile_pkg::ST_FULL;
                                state_next      = S_RESULT;
                            end
                            else
                            begin
                                // move entries up, top first
                                rem_next   = count_reg - CW'(cmd.payload.position);
                                src_next   = AW'(count_reg - CW'(1));
                                state_next = S_SHIFT;
                            end
                        end
                        ile_pkg::CMD_ERASE:
                        begin
                            if (cmd_pos_ext >= count_ext)
                            begin
                                res_status_next = ile_pkg::ST_BAD_POS;
                                state_next      = S_RESULT;
                            end
                            else
                            begin
                                // move entries down, lowest first
                                rem_next   = count_reg - CW'(cmd.payload.position) - CW'(1);
                                src_next   = AW'(cmd.payload.position) + AW'(1);
                                state_next = S_SHIFT;
                            end
                        end
                        default:
                        begin
                            rem_next   = count_reg;
                            src_next   = '0;
                            state_next = S_SHIFT;
                        end
                    endcase
                end
            end

            S_RDWAIT:
            begin
                res_rd_next = ile_pkg::VALUE_BITS'(mem_rd_reg);
                state_next  = S_RESULT;
            end

            S_SHIFT:
            begin
                // issue one read per cycle, write or compare it the next cycle
                if (rem_reg != '0)
                begin
                    mem_re   = 1'b1;
                    rem_next = rem_reg - CW'(1);
                    pv_next  = 1'b1;
                    case (op_reg)
                        ile_pkg::CMD_INSERT:
                        begin
                            dst_next = src_reg + AW'(1);
                            src_next = src_reg - AW'(1);
                        end
                        ile_pkg::CMD_ERASE:
                        begin
                            dst_next = src_reg - AW'(1);
                            src_next = src_reg + AW'(1);
                        end
                        default:
                        begin
                            dst_next = src_reg;
                            src_next = src_reg + AW'(1);
                        end
                    endcase
                end
                else
                begin
                    pv_next = 1'b0;
                end

                if (op_reg == ile_pkg::CMD_FIND)
                begin
                    if (pv_reg && (mem_rd_reg == val_reg))
                    begin
                        res_fp_next = ile_pkg::FP_BITS'(dst_reg);
                        pv_next     = 1'b0;
                        state_next  = S_RESULT;
                    end
                    else if ((rem_reg == '0) && !pv_reg)
                    begin
                        res_status_next = ile_pkg::ST_NOT_FOUND;
                        state_next      = S_RESULT;
                    end
                end
                else
                begin
                    mem_we = pv_reg;
                    if ((rem_reg == '0) && !pv_reg)
                    begin
                        if (op_reg == ile_pkg::CMD_INSERT)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = S_RESULT;
                        end
                    end
                end
            end

            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next.status         = res_status_reg;
                    out_next.read_value     = res_rd_reg;
                    out_next.found_position = res_fp_reg;
                    out_next.entry_count    = ile_pkg::COUNT_BITS'(count_reg);
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= ile_pkg::CMD_READ;
            pos_reg        <= '0;
            val_reg        <= '0;
            count_reg      <= '0;
            rem_reg        <= '0;
            src_reg        <= '0;
            dst_reg        <= '0;
            pv_reg         <= 1'b0;
            res_status_reg <= ile_pkg::ST_OK;
            res_rd_reg     <= '0;
            res_fp_reg     <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            pos_reg        <= pos_next;
            val_reg        <= val_next;
            count_reg      <= count_next;
            rem_reg        <= rem_next;
            src_reg        <= src_next;
            dst_reg        <= dst_next;
            pv_reg         <= pv_next;
            res_status_reg <= res_status_next;
            res_rd_reg     <= res_rd_next;
            res_fp_reg     <= res_fp_next;
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the indexed list engine against a behavioral copy of the list.
// Commands are driven on the cmd channel with random gaps. Each accepted
// command updates the copy and queues the result it should give. Results
// taken from the rsp channel under random back-pressure are compared field
// by field. A directed opening covers empty and full lists and bad
// positions. Random phases follow that fill and drain the list.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAPACITY  = 16;
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned LIMIT     = 500000;
    localparam int unsigned PHASES    = 10;
    localparam int unsigned PHASE_LEN = 152;

    class list_checker;
        logic [ile_pkg::VALUE_BITS-1:0] words [CAPACITY];
        int unsigned                    fill;
        ile_pkg::rsp_item_t             pending_results [$];
        int unsigned                    errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // work out the result of one command and apply it to the list copy
        function void note_command(ile_pkg::cmd_item_t c);
            ile_pkg::rsp_item_t r;
            int unsigned        p;
            int unsigned        i;
            p = 32'(c.position);
            r = '0;
            r.status = ile_pkg::ST_OK;
            case (c.command)
                ile_pkg::CMD_READ:
                begin
                    if (p >= fill)
                        r.status = ile_pkg::ST_BAD_POS;
                    else
                        r.read_value = words[p];
                end
                ile_pkg::CMD_INSERT:
                begin
                    if (p > fill)
                        r.status = ile_pkg::ST_BAD_POS;
                    else if (fill >= CAPACITY)
                        r.status = ile_pkg::ST_FULL;
                    else
                    begin
                        for (i = fill; i > p; i--)
                            words[i] = words[i - 1];
                        words[p] = c.value;
                        fill++;
                    end
                end
                ile_pkg::CMD_ERASE:
                begin
                    if (p >= fill)
                        r.status = ile_pkg::ST_BAD_POS;
                    else
                    begin
                        for (i = p; i + 1 < fill; i++)
                            words[i] = words[i + 1];
                        fill--;
                    end
                end
                default:
                begin
                    r.status = ile_pkg::ST_NOT_FOUND;
                    for (i = 0; i < fill; i++)
                    begin
                        if (words[i] == c.value)
                        begin
                            r.status         = ile_pkg::ST_OK;
                            r.found_position = ile_pkg::FP_BITS'(i);
                            break;
                        end
                    end
                end
            endcase
            r.entry_count = ile_pkg::COUNT_BITS'(fill);
            pending_results.push_back(r);
        endfunction

        function void check_result(ile_pkg::rsp_item_t got);
            ile_pkg::rsp_item_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time,
                         want.status, got.status);
                errors++;
            end
            if (got.read_value !== want.read_value)
            begin
                $display("%0t: read_value expected %h actual %h", $time,
                         want.read_value, got.read_value);
                errors++;
            end
            if (got.found_position !== want.found_position)
            begin
                $display("%0t: found_position expected %0d actual %0d", $time,
                         want.found_position, got.found_position);
                errors++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $display("%0t: entry_count expected %0d actual %0d", $time,
                         want.entry_count, got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ile_chan_if #(.payload_t(ile_pkg::cmd_item_t)) cmd_ch ();
    ile_chan_if #(.payload_t(ile_pkg::rsp_item_t)) rsp_ch ();

    list_checker lists = new();

    int unsigned gap_max         = 6;
    int unsigned stall_max       = 6;
    int unsigned rsp_hold_cycles = 0;
    int unsigned cycles          = 0;

    indexed_list_engine #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // offer one command after a random gap and wait until it is taken
    task automatic send_command(ile_pkg::cmd_t c, logic [ile_pkg::POS_BITS-1:0] p,
                                logic [ile_pkg::VALUE_BITS-1:0] v);
        ile_pkg::cmd_item_t item;
        int unsigned        gap;
        item.command  = c;
        item.position = p;
        item.value    = v;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= item;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        lists.note_command(item);
    endtask

    // mostly in-range positions, values often taken from the list for find hits
    task automatic send_random(int unsigned insert_pct);
        int unsigned                    r;
        ile_pkg::cmd_t                  c;
        logic [ile_pkg::POS_BITS-1:0]   p;
        logic [ile_pkg::VALUE_BITS-1:0] v;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
            c = ile_pkg::CMD_INSERT;
        else if (r < insert_pct + (100 - insert_pct) / 2)
            c = ile_pkg::CMD_ERASE;
        else if ($urandom_range(0, 1) == 0)
            c = ile_pkg::CMD_READ;
        else
            c = ile_pkg::CMD_FIND;

        if ($urandom_range(0, 9) < 2)
            p = ile_pkg::POS_BITS'($urandom_range(0, 31));
        else if (c == ile_pkg::CMD_INSERT)
            p = ile_pkg::POS_BITS'($urandom_range(0, lists.fill));
        else if (lists.fill == 0)
            p = '0;
        else
            p = ile_pkg::POS_BITS'($urandom_range(0, lists.fill - 1));

        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = ile_pkg::VALUE_BITS'($urandom_range(0, 7));
            2: v = (lists.fill == 0) ? $urandom : lists.words[$urandom_range(0, lists.fill - 1)];
            default: v = ($urandom_range(0, 1) == 0) ? '0 : '1;
        endcase
        send_command(c, p, v);
    endtask

    // pause the sender until every queued result has come back
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (lists.pending_results.size() != 0);
    endtask

    initial
    begin
        int unsigned stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rsp_hold_cycles > 0)
            begin
                stall           = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            else
                stall = $urandom_range(0, stall_max);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            lists.check_result(rsp_ch.payload);
        end
    end

    initial
    begin
        int unsigned                    phase;
        int unsigned                    n;
        int unsigned                    pct;
        logic [ile_pkg::VALUE_BITS-1:0] v;
        rst_n          <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.payload <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty list corner cases
        send_command(ile_pkg::CMD_READ, 5'd0, '0);
        send_command(ile_pkg::CMD_ERASE, 5'd0, '0);
        send_command(ile_pkg::CMD_FIND, 5'd0, '0);
        send_command(ile_pkg::CMD_INSERT, 5'd1, 32'd5);
        // fill to capacity at shifting positions, with one duplicate word
        for (n = 0; n < CAPACITY; n++)
        begin
            if (n == 0)
                v = '0;
            else if (n == CAPACITY - 1)
                v = '1;
            else if (n == 9)
                v = 32'hA5A5_0003;
            else
                v = 32'hA5A5_0000 + n;
            send_command(ile_pkg::CMD_INSERT, ile_pkg::POS_BITS'((n * 7) % (n + 1)), v);
        end
        send_command(ile_pkg::CMD_INSERT, 5'd0, 32'd7);
        // range check wins over the full check
        send_command(ile_pkg::CMD_INSERT, 5'd17, 32'd7);
        send_command(ile_pkg::CMD_READ, 5'd16, '0);
        send_command(ile_pkg::CMD_READ, 5'd15, '0);
        send_command(ile_pkg::CMD_FIND, 5'd0, 32'hA5A5_0003);
        send_command(ile_pkg::CMD_ERASE, 5'd31, '0);
        send_command(ile_pkg::CMD_ERASE, 5'd0, '0);
        drain_results();

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0: begin gap_max = 6; stall_max = 6; end
                1: begin gap_max = 0; stall_max = 0; end
                2: begin gap_max = 0; stall_max = 6; end
                default: begin gap_max = 6; stall_max = 0; end
            endcase
            case (phase % 3)
                0: pct = 70;
                1: pct = 20;
                default: pct = 45;
            endcase
            // long receiver hold while commands keep coming back to back
            if (phase == 2)
                rsp_hold_cycles = 400;
            for (n = 0; n < PHASE_LEN; n++)
                send_random(pct);
            drain_results();
        end

        repeat (40) @(posedge clk);
        if (lists.errors == 0 && lists.pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
